// ===== rtl/dpfd_pkg.sv =====
// ----------------------------------------------------------------------------
// dpfd_pkg
// Shared types and constants for the single-wire sensor frame decoder.
// ----------------------------------------------------------------------------
package dpfd_pkg;

    localparam int FRAME_INTERVALS = 41;
    localparam int DATA_BITS       = FRAME_INTERVALS - 1;
    localparam int CNT_W           = $clog2(FRAME_INTERVALS);
    localparam int IV_W            = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int BYTE_W          = 8;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_INTERVALS - 1);

    localparam logic OP_EDGE  = 1'b0;
    localparam logic OP_ABORT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ACK_MIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = 2'd2;

    localparam logic [IV_W-1:0] ACK_MIN_RST   = 16'd50;
    localparam logic [IV_W-1:0] ZERO_LOW_RST  = 16'd60;
    localparam logic [IV_W-1:0] ZERO_HIGH_RST = 16'd100;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ACK_ERR = 2'd1,
        ST_CKS_ERR = 2'd2
    } status_t;

    typedef struct packed {
        logic [IV_W-1:0] ack_min_us;
        logic [IV_W-1:0] zero_low_us;
        logic [IV_W-1:0] zero_high_us;
    } cfg_t;

    typedef struct packed {
        logic                 done;
        logic                 ack_failed;
        logic [DATA_BITS-1:0] bits;
    } frame_t;

    typedef struct packed {
        status_t          status;
        logic signed [15:0] temperature_tenths;
        logic [15:0]      humidity_tenths;
    } result_t;

endpackage

// ===== rtl/dpfd_frame_capture.sv =====
// ----------------------------------------------------------------------------
// dpfd_frame_capture
// Counts intervals, checks the acknowledge and shifts in decoded data bits.
// ----------------------------------------------------------------------------
module dpfd_frame_capture
    import dpfd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  cfg_t            cfg,
    input  logic            take,
    input  logic            op,
    input  logic [IV_W-1:0] interval_us,
    output logic            last_interval,
    output frame_t          frame
);

    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 ack_failed_reg, ack_failed_next;
    logic [DATA_BITS-1:0] bits_reg, bits_next;
    logic                 bit_val;
    logic [DATA_BITS-1:0] shifted;

    assign last_interval = (op == OP_EDGE) && (count_reg == CNT_LAST);

    assign bit_val = !((interval_us > cfg.zero_low_us) && (interval_us < cfg.zero_high_us));
    assign shifted = {bits_reg[DATA_BITS-2:0], bit_val};

    always_comb
    begin
        count_next      = count_reg;
        ack_failed_next = ack_failed_reg;
        bits_next       = bits_reg;
        frame.done       = 1'b0;
        frame.ack_failed = ack_failed_reg;
        frame.bits       = shifted;
        if (take)
        begin
            if (op == OP_ABORT)
            begin
                count_next      = '0;
                ack_failed_next = 1'b0;
                bits_next       = '0;
            end
            else if (count_reg == '0)
            begin
                count_next      = CNT_W'(1);
                ack_failed_next = interval_us < cfg.ack_min_us;
            end
            else if (count_reg == CNT_LAST)
            begin
                frame.done      = 1'b1;
                count_next      = '0;
                ack_failed_next = 1'b0;
                bits_next       = '0;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
                bits_next  = shifted;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            ack_failed_reg <= 1'b0;
            bits_reg       <= '0;
        end
        else
        begin
            count_reg      <= count_next;
            ack_failed_reg <= ack_failed_next;
            bits_reg       <= bits_next;
        end
    end

endmodule

// ===== rtl/dpfd_result_format.sv =====
// ----------------------------------------------------------------------------
// dpfd_result_format
// Checks the byte-sum checksum and decodes humidity and sign-magnitude
// temperature from a complete frame.
// ----------------------------------------------------------------------------
module dpfd_result_format
    import dpfd_pkg::*;
(
    input  frame_t  frame,
    output result_t result
);

    logic [BYTE_W-1:0] b1, b2, b3, b4, b5;
    logic [BYTE_W-1:0] sum;
    logic [14:0]       mag;
    logic [15:0]       mag_ext;

    assign b1 = frame.bits[39:32];
    assign b2 = frame.bits[31:24];
    assign b3 = frame.bits[23:16];
    assign b4 = frame.bits[15:8];
    assign b5 = frame.bits[7:0];

    assign sum     = (b1 + b2) + (b3 + b4);
    assign mag     = {b3[6:0], b4};
    assign mag_ext = {1'b0, mag};

    always_comb
    begin
        result.status             = ST_OK;
        result.temperature_tenths = '0;
        result.humidity_tenths    = '0;
        if (frame.ack_failed)
        begin
            result.status = ST_ACK_ERR;
        end
        else if (b5 != sum)
        begin
            result.status = ST_CKS_ERR;
        end
        else
        begin
            result.humidity_tenths    = {b1, b2};
            result.temperature_tenths = b3[7] ? $signed(16'd0 - mag_ext) : $signed(mag_ext);
        end
    end

endmodule

// ===== rtl/dpfd_out_reg.sv =====
// ----------------------------------------------------------------------------
// dpfd_out_reg
// Result register with valid/ready handshake toward the receiver.
// ----------------------------------------------------------------------------
module dpfd_out_reg
    import dpfd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result_in,
    input  logic    out_ready,
    output logic    out_valid,
    output logic    busy,
    output result_t result_out
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign busy       = valid_reg && !out_ready;
    assign out_valid  = valid_reg;
    assign result_out = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result_in;
        end
    end

endmodule

// ===== rtl/dht_pulse_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// dht_pulse_frame_decoder
// Decodes single-wire sensor frames from measured falling-edge intervals.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one transfer per interval, op selects an
// edge interval or an abort that drops a partial frame. A frame is the
// acknowledge interval followed by 40 data intervals, most significant bit
// first. Output channel (out_valid/out_ready): one transfer per completed
// frame with status, humidity and temperature in tenths.
// Throughput is one input transfer per cycle while in_ready is high, set by
// the single compare and shift stage of the frame capture. out_valid rises in
// the cycle after the last interval is taken, through the result register.
// While a result is stalled by out_ready low, intervals that do not finish a
// frame are still taken; the interval that finishes the next frame waits
// until the result register frees.
// Reset clears the frame state and the result valid flag and loads the
// default window registers; configuration writes via cfg_we take effect at
// once and must be made while no frame is in progress.
// ----------------------------------------------------------------------------
module dht_pulse_frame_decoder
    import dpfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [IV_W-1:0]      cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 op,
    input  logic [IV_W-1:0]      interval_us,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic signed [15:0]   temperature_tenths,
    output logic [15:0]          humidity_tenths
);

    cfg_t    cfg_reg;
    frame_t  frame;
    result_t result;
    result_t result_q;
    logic    last_interval;
    logic    busy;
    logic    take;

    assign in_ready = !(busy && last_interval);
    assign take     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ack_min_us   <= ACK_MIN_RST;
            cfg_reg.zero_low_us  <= ZERO_LOW_RST;
            cfg_reg.zero_high_us <= ZERO_HIGH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ACK_MIN:   cfg_reg.ack_min_us   <= cfg_data;
                CFG_ZERO_LOW:  cfg_reg.zero_low_us  <= cfg_data;
                CFG_ZERO_HIGH: cfg_reg.zero_high_us <= cfg_data;
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    dpfd_frame_capture u_capture (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .take          (take),
        .op            (op),
        .interval_us   (interval_us),
        .last_interval (last_interval),
        .frame         (frame)
    );

    dpfd_result_format u_format (
        .frame  (frame),
        .result (result)
    );

    dpfd_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (frame.done),
        .result_in  (result),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .busy       (busy),
        .result_out (result_q)
    );

    assign status             = result_q.status;
    assign temperature_tenths = result_q.temperature_tenths;
    assign humidity_tenths    = result_q.humidity_tenths;

endmodule

// ===== rtl/dpfd_checker.sv =====
// ----------------------------------------------------------------------------
// dpfd_checker
// Port-level checks for the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module dpfd_checker
    import dpfd_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [1:0]         status,
    input logic signed [15:0] temperature_tenths,
    input logic [15:0]        humidity_tenths
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(temperature_tenths) && $stable(humidity_tenths))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == ST_OK || status == ST_ACK_ERR || status == ST_CKS_ERR)
        else $error("undefined status code");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> temperature_tenths == 16'sd0 && humidity_tenths == 16'd0)
        else $error("error result carries nonzero readings");

    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result without an input transfer");

    a_new_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $past(out_valid && out_ready) && out_valid |-> $past(in_valid && in_ready))
        else $error("back-to-back result without an input transfer");

endmodule

bind dht_pulse_frame_decoder dpfd_checker u_dpfd_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .status             (status),
    .temperature_tenths (temperature_tenths),
    .humidity_tenths    (humidity_tenths)
);

// ===== tb/sv/dht_pulse_frame_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// dht_pulse_frame_decoder_tb
// Self-checking bench for the single-wire sensor frame decoder. Builds frames
// of acknowledge and data intervals from chosen bytes under several window
// settings, mixes in aborts, broken frames and loose intervals, and drives
// them with random idle gaps. Each frame result is checked field by field
// against an in-bench decoder while the output side stalls at random.
// ----------------------------------------------------------------------------
module dht_pulse_frame_decoder_tb
    import dpfd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int ITEM_TARGET  = 1550;
    localparam int FRAME_TARGET = 30;
    localparam int PHASE_ITEMS  = 180;

    typedef struct {
        logic            op;
        logic [IV_W-1:0] iv;
        bit              drain;
    } interval_item_t;

    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = CFG_ACK_MIN;
    logic [IV_W-1:0]      cfg_data    = '0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic                 op          = OP_EDGE;
    logic [IV_W-1:0]      interval_us = '0;
    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    logic [1:0]           status;
    logic signed [15:0]   temperature_tenths;
    logic [15:0]          humidity_tenths;

    interval_item_t interval_q[$];
    result_t        frame_results_q[$];

    logic [IV_W-1:0] ack_floor = ACK_MIN_RST;
    logic [IV_W-1:0] win_lo    = ZERO_LOW_RST;
    logic [IV_W-1:0] win_hi    = ZERO_HIGH_RST;

    int              frame_len = 0;
    bit              ack_low   = 1'b0;
    logic [39:0]     data_bits = '0;

    int results_predicted = 0;
    int results_seen      = 0;
    int mismatch_cnt      = 0;
    int cycle_cnt         = 0;
    int gap_in            = 0;
    int calm_in           = 0;
    int stall_out         = 0;
    int calm_out          = 0;

    int items_made  = 0;
    int frames_made = 0;
    int phase_made  = 0;
    int gen_pos     = 0;

    dht_pulse_frame_decoder u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .op                 (op),
        .interval_us        (interval_us),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .status             (status),
        .temperature_tenths (temperature_tenths),
        .humidity_tenths    (humidity_tenths)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic decode_interval(input logic op_i, input logic [IV_W-1:0] iv,
                                             output result_t res);
        logic [7:0]  hb, lb, th, tl, cks;
        logic [14:0] mag;
        res = '0;
        if (op_i == OP_ABORT)
        begin
            frame_len = 0;
            ack_low   = 1'b0;
            data_bits = '0;
            return 1'b0;
        end
        if (frame_len == 0)
        begin
            ack_low   = iv < ack_floor;
            frame_len = 1;
            return 1'b0;
        end
        data_bits = {data_bits[38:0], !(iv > win_lo && iv < win_hi)};
        frame_len++;
        if (frame_len < FRAME_INTERVALS)
            return 1'b0;
        {hb, lb, th, tl, cks} = data_bits;
        if (ack_low)
            res.status = ST_ACK_ERR;
        else if (cks != 8'(hb + lb + th + tl))
            res.status = ST_CKS_ERR;
        else
        begin
            mag = {th[6:0], tl};
            res.status             = ST_OK;
            res.humidity_tenths    = {hb, lb};
            res.temperature_tenths = th[7] ? 16'(-{1'b0, mag}) : {1'b0, mag};
        end
        frame_len = 0;
        ack_low   = 1'b0;
        data_bits = '0;
        return 1'b1;
    endfunction

    function automatic int pick_idle();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return 0;
        if (roll < 88)
            return $urandom_range(3, 1);
        if (roll < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // Sender: predict on each transfer, then hold, idle or launch the next item.
    always @(posedge clk or negedge rst_n)
    begin
        result_t        res;
        logic           made;
        interval_item_t next_it;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            op          <= OP_EDGE;
            interval_us <= '0;
            gap_in      <= 0;
            calm_in     <= 0;
        end
        else
        begin
            made = 1'b0;
            if (in_valid && in_ready)
            begin
                made = decode_interval(op, interval_us, res);
                if (made)
                    frame_results_q.push_back(res);
            end
            if (in_valid && !in_ready)
            begin
            end
            else if (gap_in != 0)
            begin
                in_valid <= 1'b0;
                gap_in   <= gap_in - 1;
            end
            else if (interval_q.size() != 0 &&
                     !(interval_q[0].drain && results_predicted + made != results_seen))
            begin
                next_it     = interval_q.pop_front();
                in_valid    <= 1'b1;
                op          <= next_it.op;
                interval_us <= next_it.iv;
                if (calm_in != 0)
                    calm_in <= calm_in - 1;
                else if ($urandom_range(99) < 2)
                    calm_in <= $urandom_range(150, 40);
                else
                    gap_in <= pick_idle();
            end
            else
                in_valid <= 1'b0;
            results_predicted <= results_predicted + made;
        end
    end

    // Receiver: check each transfer against the oldest expected frame result.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_out <= 0;
            calm_out  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (frame_results_q.size() == 0)
                begin
                    $display("%0t: unexpected result status %0d temp %0d hum %0d",
                             $time, status, temperature_tenths, humidity_tenths);
                    mismatch_cnt++;
                end
                else
                begin
                    want = frame_results_q.pop_front();
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, status);
                        mismatch_cnt++;
                    end
                    if (temperature_tenths !== want.temperature_tenths)
                    begin
                        $display("%0t: temperature_tenths expected %0d got %0d",
                                 $time, want.temperature_tenths, temperature_tenths);
                        mismatch_cnt++;
                    end
                    if (humidity_tenths !== want.humidity_tenths)
                    begin
                        $display("%0t: humidity_tenths expected %0d got %0d",
                                 $time, want.humidity_tenths, humidity_tenths);
                        mismatch_cnt++;
                    end
                end
            end
            if (stall_out != 0)
            begin
                out_ready <= 1'b0;
                stall_out <= stall_out - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                if (calm_out != 0)
                    calm_out <= calm_out - 1;
                else if ($urandom_range(99) < 1)
                    calm_out <= $urandom_range(200, 50);
                else if ($urandom_range(99) < 30)
                    stall_out <= pick_idle();
            end
        end
    end

    task automatic push_item(input logic op_i, input logic [IV_W-1:0] iv, input bit drain);
        interval_item_t it;
        it.op    = op_i;
        it.iv    = iv;
        it.drain = drain;
        interval_q.push_back(it);
        items_made++;
        phase_made++;
        if (op_i == OP_ABORT)
            gen_pos = 0;
        else
        begin
            gen_pos++;
            if (gen_pos == FRAME_INTERVALS)
            begin
                gen_pos = 0;
                frames_made++;
            end
        end
    endtask

    function automatic logic [IV_W-1:0] pick_bit_interval(input bit one);
        logic [16:0] lo1;
        int          roll;
        lo1  = {1'b0, win_lo} + 17'd1;
        roll = $urandom_range(99);
        if (!one && lo1 < {1'b0, win_hi})
        begin
            if (roll < 20)
                return lo1[15:0];
            if (roll < 40)
                return win_hi - 16'd1;
            return 16'($urandom_range(win_hi - 16'd1, lo1[15:0]));
        end
        if (roll < 10)
            return win_lo;
        if (roll < 20)
            return win_hi;
        if (roll < 25)
            return 16'd0;
        if (roll < 30)
            return 16'hFFFF;
        if (roll < 65)
            return 16'($urandom_range(win_lo, 0));
        return 16'($urandom_range(16'hFFFF, win_hi));
    endfunction

    function automatic logic [IV_W-1:0] pick_ack_interval(input bit bad);
        int roll;
        roll = $urandom_range(99);
        if (bad && ack_floor != 0)
        begin
            if (roll < 30)
                return ack_floor - 16'd1;
            return 16'($urandom_range(ack_floor - 16'd1, 0));
        end
        if (roll < 20)
            return ack_floor;
        if (roll < 30)
            return 16'hFFFF;
        return 16'($urandom_range(16'hFFFF, ack_floor));
    endfunction

    function automatic logic [39:0] frame_data(input logic [7:0] hb, lb, th, tl,
                                               input bit good);
        return {hb, lb, th, tl, good ? 8'(hb + lb + th + tl) : 8'($urandom())};
    endfunction

    task automatic push_frame(input logic [39:0] data, input bit ack_bad, input bit noisy,
                              input bit drain);
        if (gen_pos != 0)
            push_item(OP_ABORT, 16'($urandom()), 1'b0);
        push_item(OP_EDGE, pick_ack_interval(ack_bad), drain);
        for (int i = 39; i >= 0; i--)
            push_item(OP_EDGE, noisy ? 16'($urandom()) : pick_bit_interval(data[i]), 1'b0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [IV_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ACK_MIN:   ack_floor = val;
            CFG_ZERO_LOW:  win_lo    = val;
            CFG_ZERO_HIGH: win_hi    = val;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (interval_q.size() != 0 || in_valid || frame_results_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int              phase;
        int              roll;
        logic [IV_W-1:0] lo_v;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        for (phase = 0; items_made < ITEM_TARGET || frames_made < FRAME_TARGET; phase++)
        begin
            if (phase != 0)
            begin
                wait_idle();
                case (phase)
                    1:
                    begin
                        write_reg(CFG_ACK_MIN, 16'd0);
                        write_reg(CFG_ZERO_LOW, 16'd0);
                        write_reg(CFG_ZERO_HIGH, 16'hFFFF);
                    end
                    2:
                    begin
                        write_reg(CFG_ACK_MIN, 16'hFFFF);
                        write_reg(CFG_ZERO_LOW, 16'hFFFF);
                        write_reg(CFG_ZERO_HIGH, 16'd0);
                    end
                    3:
                    begin
                        write_reg(CFG_ACK_MIN, 16'd1);
                        write_reg(CFG_ZERO_LOW, 16'd99);
                        write_reg(CFG_ZERO_HIGH, 16'd101);
                    end
                    4:
                    begin
                        write_reg(CFG_ACK_MIN, 16'd20);
                        write_reg(CFG_ZERO_LOW, 16'd100);
                        write_reg(CFG_ZERO_HIGH, 16'd101);
                    end
                    5:
                    begin
                        write_reg(CFG_ACK_MIN, ACK_MIN_RST);
                        write_reg(CFG_ZERO_LOW, ZERO_LOW_RST);
                        write_reg(CFG_ZERO_HIGH, ZERO_HIGH_RST);
                    end
                    default:
                    begin
                        write_reg(CFG_ACK_MIN, $urandom_range(1) ? 16'($urandom_range(120))
                                                                 : 16'($urandom()));
                        lo_v = $urandom_range(3) != 0 ? 16'($urandom_range(200))
                                                      : 16'($urandom());
                        write_reg(CFG_ZERO_LOW, lo_v);
                        write_reg(CFG_ZERO_HIGH, 16'hFFFF - lo_v > 16'd400 ?
                                                 lo_v + 16'($urandom_range(400)) :
                                                 16'($urandom()));
                    end
                endcase
            end
            @(negedge clk);
            phase_made = 0;
            if (phase == 0)
            begin
                push_item(OP_ABORT, 16'hFFFF, 1'b0);
                push_item(OP_ABORT, 16'd0, 1'b0);
                push_item(OP_EDGE, 16'd0, 1'b0);
                push_item(OP_EDGE, 16'hFFFF, 1'b0);
                push_item(OP_EDGE, ZERO_LOW_RST, 1'b0);
                push_item(OP_EDGE, ZERO_LOW_RST + 16'd1, 1'b0);
                push_item(OP_EDGE, ZERO_HIGH_RST - 16'd1, 1'b0);
                push_item(OP_EDGE, ZERO_HIGH_RST, 1'b0);
                push_item(OP_ABORT, 16'h5A5A, 1'b0);
                push_frame(frame_data(8'h02, 8'h8C, 8'h80, 8'h65, 1'b1), 1'b0, 1'b0, 1'b1);
                push_frame(frame_data(8'h01, 8'h00, 8'h80, 8'h00, 1'b1), 1'b0, 1'b0, 1'b0);
                push_frame(frame_data(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1), 1'b0, 1'b0, 1'b0);
                push_frame(frame_data(8'h00, 8'h00, 8'h00, 8'h00, 1'b1), 1'b0, 1'b0, 1'b0);
                push_frame(frame_data(8'h02, 8'h10, 8'h01, 8'h2C, 1'b1), 1'b1, 1'b0, 1'b1);
                push_frame(40'h01_02_03_04_0B, 1'b0, 1'b0, 1'b0);
            end
            while (phase_made < PHASE_ITEMS)
            begin
                roll = $urandom_range(99);
                if (roll < 75)
                    push_frame(frame_data(8'($urandom()), 8'($urandom()), 8'($urandom()),
                                          8'($urandom()), $urandom_range(99) < 80),
                               $urandom_range(99) < 10, $urandom_range(99) < 10,
                               $urandom_range(99) < 4);
                else if (roll < 88)
                begin
                    if (gen_pos != 0)
                        push_item(OP_ABORT, 16'($urandom()), 1'b0);
                    push_item(OP_EDGE, pick_ack_interval($urandom_range(99) < 20), 1'b0);
                    repeat ($urandom_range(39))
                        push_item(OP_EDGE, pick_bit_interval($urandom_range(1)), 1'b0);
                    push_item(OP_ABORT, 16'($urandom()), 1'b0);
                end
                else
                    push_item($urandom_range(99) < 30 ? OP_ABORT : OP_EDGE,
                              16'($urandom()), 1'b0);
            end
            if (gen_pos != 0)
                push_item(OP_ABORT, 16'($urandom()), 1'b0);
        end
        wait_idle();
        if (mismatch_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
